@@ hw/rtl/bmh_pkg.sv @@
// Shared types and codes for the binary max-heap priority queue.
// No dependencies.
package bmh_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       take;       // input beat accepted
    logic       ins_setup;  // grow count, new hole at the end
    logic       rd_parent;  // read parent of hole
    logic       up_step;    // sift-up compare and write
    logic       rd_ends;    // read root and last entry
    logic       rm_load;    // latch max and last, shrink count
    logic       rd_kids;    // read both children of hole
    logic       dn_step;    // sift-down compare and write
    logic       place;      // write moving value into hole
    logic       set_st;
    logic [1:0] st;
    logic       load_out;   // load output beat registers
  } bmh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_left;
    logic up_move;
    logic dn_move;
  } bmh_stat_t;

endpackage

@@ hw/rtl/bmh_datapath.sv @@
// Heap store, entry count, hole position and output beat registers.
// Depends on bmh_pkg.
module bmh_datapath
  import bmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  bmh_cmd_t           cmd,
  output bmh_stat_t          stat,
  input  logic signed [31:0] value,
  output logic [1:0]         status,
  output logic signed [31:0] max_value,
  output logic [10:0]        occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [31:0] mem [CAPACITY];

  logic [CW-1:0]      count;
  logic [CW-1:0]      pos;
  logic signed [31:0] v;
  logic signed [31:0] maxv;
  logic [1:0]         st;
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          wen;

  logic [CW:0]        left;
  logic [CW:0]        right;
  logic [CW-1:0]      parent;
  logic               right_ok;
  logic               left_gt;
  logic               right_gt;
  logic signed [31:0] cand;

  assign left     = {pos, 1'b0};
  assign right    = left + (CW+1)'(1);
  assign parent   = pos >> 1;
  assign right_ok = right <= {1'b0, count};
  assign left_gt  = rd_a > v;
  assign cand     = left_gt ? rd_a : v;
  assign right_gt = right_ok && (rd_b > cand);

  assign stat.full    = count == CW'(CAPACITY);
  assign stat.empty   = count == '0;
  assign stat.at_root = pos == CW'(1);
  assign stat.no_left = left > {1'b0, count};
  assign stat.up_move = v > rd_a;
  assign stat.dn_move = left_gt || right_gt;

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (cmd.rd_parent) begin
      addr_a = AW'(parent - CW'(1));
    end else if (cmd.rd_ends) begin
      addr_b = AW'(count - CW'(1));
    end else if (cmd.rd_kids) begin
      addr_a = AW'(left - (CW+1)'(1));
      addr_b = AW'(left);
    end
  end

  always_comb begin
    waddr = AW'(pos - CW'(1));
    wen   = cmd.place || cmd.up_step || cmd.dn_step;
    wdata = v;
    if (cmd.up_step && stat.up_move) begin
      wdata = rd_a;
    end else if (cmd.dn_step && stat.dn_move) begin
      wdata = right_gt ? rd_b : rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_setup) begin
      count <= count + CW'(1);
    end else if (cmd.rm_load) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      maxv <= '0;
    end else if (cmd.rm_load) begin
      maxv <= rd_a;
    end
    if (cmd.ins_setup) begin
      pos <= count + CW'(1);
      v   <= value;
    end else if (cmd.rm_load) begin
      pos <= CW'(1);
      v   <= rd_b;
    end else if (cmd.up_step && stat.up_move) begin
      pos <= parent;
    end else if (cmd.dn_step && stat.dn_move) begin
      pos <= right_gt ? CW'(right) : CW'(left);
    end
    if (cmd.set_st) begin
      st <= cmd.st;
    end
    if (cmd.load_out) begin
      status    <= st;
      max_value <= maxv;
      occupancy <= 11'(count);
    end
  end

endmodule

@@ hw/rtl/bmh_ctrl.sv @@
// Sequencer for insert sift-up, remove sift-down and output beat handoff.
// Depends on bmh_pkg.
module bmh_ctrl
  import bmh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      command,
  output logic      out_valid,
  input  logic      out_ready,
  input  bmh_stat_t stat,
  output bmh_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_RM_LOAD = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (command == CMD_INSERT) begin
            if (stat.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
              state_next = S_FIN;
            end else begin
              cmd.ins_setup = 1'b1;
              state_next    = S_UP_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
              state_next = S_FIN;
            end else begin
              cmd.rd_ends = 1'b1;
              state_next  = S_RM_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place  = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_INSERTED;
          state_next = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        if (stat.up_move) begin
          state_next = S_UP_RD;
        end else begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_INSERTED;
          state_next = S_FIN;
        end
      end
      S_RM_LOAD: begin
        cmd.rm_load = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.no_left) begin
          cmd.place  = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_REMOVED;
          state_next = S_FIN;
        end else begin
          cmd.rd_kids = 1'b1;
          state_next  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        if (stat.dn_move) begin
          state_next = S_DN_RD;
        end else begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_REMOVED;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue: controller plus datapath.
// Depends on bmh_pkg, bmh_ctrl, bmh_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   input   | in_valid / in_ready  | command, value
//   output  | out_valid / out_ready| status, max_value, occupancy
//
// One item at a time, taken only when idle. Insert climbs a level per parent
// read and compare and stops at the root or when a compare ends it; remove
// reads the root and last entry, latches them, then descends a level per child
// read and compare until there is no left child or a compare ends it; each step
// waits on the registered reads of the heap store. Full and empty go to handoff.
// Reset clears the count, the controller state and out_valid, not the store.
// A result held by out_ready low does not block the next item; only the
// handoff of the following result waits.
module binary_max_heap_priority_queue
  import bmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] max_value,
  output logic [10:0]        occupancy
);

  bmh_cmd_t  cmd;
  bmh_stat_t stat;

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (value),
    .status    (status),
    .max_value (max_value),
    .occupancy (occupancy)
  );

endmodule
